// ===== rtl/partial_exchange_sort_with_index_top_macros.svh =====
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef PARTIAL_EXCHANGE_SORT_WITH_INDEX_TOP_MACROS_SVH
`define PARTIAL_EXCHANGE_SORT_WITH_INDEX_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define PESI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define PESI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pesi_pkg.sv =====
// types and constants of the partial exchange sort block
// no dependencies; used by the top level and its checker
package pesi_pkg;

    localparam int KEY_W          = 32;
    localparam int TAG_W          = 16;
    localparam int SEL_W          = 7;
    localparam int MAX_ITEMS_DEF  = 64;
    localparam int RESULT_LIMIT   = 64;
    localparam logic [SEL_W-1:0] SEL_RESET = 7'd1;

    typedef struct packed {
        logic signed [KEY_W-1:0] key_value;
        logic        [TAG_W-1:0] tag_index;
        logic                    last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_value;
        logic        [TAG_W-1:0] sorted_tag;
        logic                    last_result;
    } t_out_item;

endpackage

// ===== rtl/partial_exchange_sort_with_index_top.sv =====
// Partial exchange sort with index tags. Items are loaded one per cycle
// (o_in_ready stays high while a set loads); items past MAX_ITEMS are dropped, but a
// dropped item with last_item set still starts the sort. On the last item the block
// stops taking input and runs the exchange sort for positions 0..m-1, with
// m = min(select_count, loaded count, 64). All compare and swap steps go through one
// registered-read store port and one signed 32-bit comparator: position i goes through
// read, front load, n-1-i compare steps and place, and place waits while the output
// stalls. Each position is emitted as soon as it is placed; the last one carries
// last_result. With m = 0 the set ends with no result. select_count resets to 1 and is
// written through the i_cfg_wr_en / i_cfg_wr_data port; the user must write it only
// while the block is idle, which the block itself does not enforce.
module partial_exchange_sort_with_index_top #(
    parameter int MAX_ITEMS = pesi_pkg::MAX_ITEMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pesi_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pesi_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_wr_en,
    input  logic [pesi_pkg::SEL_W-1:0]  i_cfg_wr_data
);
    import pesi_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = (CW > SEL_W) ? CW : SEL_W;

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_FRONT = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_PLACE = 3'd4;

    // store
    logic signed [KEY_W-1:0] r_val_mem [MAX_ITEMS];
    logic        [TAG_W-1:0] r_tag_mem [MAX_ITEMS];
    logic signed [KEY_W-1:0] r_rd_val;
    logic        [TAG_W-1:0] r_rd_tag;

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [KEY_W-1:0] mem_wval;
    logic [TAG_W-1:0]        mem_wtag;
    logic [AW-1:0]           mem_raddr;

    // control
    logic [2:0]              r_state, n_state;
    logic [SEL_W-1:0]        r_sel;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_n, n_n;
    logic [CW-1:0]           r_m, n_m;
    logic [AW-1:0]           r_i, n_i;
    logic [AW-1:0]           r_j, n_j;
    logic signed [KEY_W-1:0] r_front_val, n_front_val;
    logic [TAG_W-1:0]        r_front_tag, n_front_tag;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out_item, n_out_item;

    logic                    in_acc;
    logic                    room;
    logic [CW-1:0]           cnt_inc;
    logic [XW-1:0]           sel_x, cnt_x, m_x;
    logic [CW-1:0]           i_next, j_next;
    logic                    out_free;

    assign in_acc   = i_in_valid && o_in_ready;
    assign room     = (r_count < CW'(MAX_ITEMS));
    assign cnt_inc  = room ? (r_count + CW'(1)) : r_count;
    assign sel_x    = XW'(r_sel);
    assign cnt_x    = XW'(cnt_inc);
    assign i_next   = CW'(r_i) + CW'(1);
    assign j_next   = CW'(r_j) + CW'(1);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        m_x = (sel_x < cnt_x) ? sel_x : cnt_x;
        if (m_x > XW'(RESULT_LIMIT)) begin
            m_x = XW'(RESULT_LIMIT);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_m         = r_m;
        n_i         = r_i;
        n_j         = r_j;
        n_front_val = r_front_val;
        n_front_tag = r_front_tag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        mem_we      = 1'b0;
        mem_waddr   = r_i;
        mem_wval    = r_front_val;
        mem_wtag    = r_front_tag;
        mem_raddr   = r_i;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    mem_we    = room;
                    mem_waddr = r_count[AW-1:0];
                    mem_wval  = i_in_item.key_value;
                    mem_wtag  = i_in_item.tag_index;
                    n_count   = cnt_inc;
                    if (i_in_item.last_item) begin
                        n_count = '0;
                        n_n     = cnt_inc;
                        n_m     = m_x[CW-1:0];
                        n_i     = '0;
                        if (m_x != '0) begin
                            n_state = S_FETCH;
                        end
                    end
                end
            end
            S_FETCH: begin
                mem_raddr = r_i;
                n_state   = S_FRONT;
            end
            S_FRONT: begin
                n_front_val = r_rd_val;
                n_front_tag = r_rd_tag;
                if (i_next < r_n) begin
                    mem_raddr = i_next[AW-1:0];
                    n_j       = i_next[AW-1:0];
                    n_state   = S_SCAN;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SCAN: begin
                // strictly smaller entry swaps into the front
                if (r_front_val > r_rd_val) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_j;
                    n_front_val = r_rd_val;
                    n_front_tag = r_rd_tag;
                end
                if (j_next < r_n) begin
                    mem_raddr = j_next[AW-1:0];
                    n_j       = j_next[AW-1:0];
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                if (out_free) begin
                    mem_we                  = 1'b1;
                    mem_waddr               = r_i;
                    n_out_valid             = 1'b1;
                    n_out_item.sorted_value = r_front_val;
                    n_out_item.sorted_tag   = r_front_tag;
                    n_out_item.last_result  = (i_next == r_m);
                    if (i_next == r_m) begin
                        n_state = S_LOAD;
                    end else begin
                        n_i     = i_next[AW-1:0];
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_val_mem[mem_waddr] <= mem_wval;
            r_tag_mem[mem_waddr] <= mem_wtag;
        end
        r_rd_val <= r_val_mem[mem_raddr];
        r_rd_tag <= r_tag_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_sel       <= SEL_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_sel <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_m         <= n_m;
        r_i         <= n_i;
        r_j         <= n_j;
        r_front_val <= n_front_val;
        r_front_tag <= n_front_tag;
        r_out_item  <= n_out_item;
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/pesi_checker.sv =====
// port-level checks for the partial exchange sort block, bound to its top level
// depends on pesi_pkg and the assertion macro header
`include "partial_exchange_sort_with_index_top_macros.svh"

module pesi_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input pesi_pkg::t_in_item          i_in_item,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input pesi_pkg::t_out_item         o_out_item
);
    import pesi_pkg::*;

    logic in_acc;
    assign in_acc   = i_in_valid && o_in_ready;

    // a stalled result item holds
`PESI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result item changed while stalled")

    // an unmarked item never stops loading
`PESI_ASSERT_NXT(a_load_on, i_clk, i_rst_n, in_acc && !i_in_item.last_item, o_in_ready, "input stalled after an unmarked item")

    // while a non-final result waits, the sort is still running
`PESI_ASSERT_IMP(a_mid_sort, i_clk, i_rst_n, o_out_valid && !o_out_item.last_result, !o_in_ready, "input open before the final result was placed")

    // loading stops only after a marked item
`PESI_ASSERT_IMP(a_stop_cause, i_clk, i_rst_n, $fell(o_in_ready), $past(in_acc && i_in_item.last_item), "input stalled without a marked item")

endmodule

bind partial_exchange_sort_with_index_top pesi_checker u_pesi_checker (.*);
